@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared wrappers for the concurrent assertions of the ring allocator checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is high
`define VERA_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ring allocator assertion failed");

// clocked assertion that also holds through reset
`define VERA_ASSERT_NR(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("ring allocator assertion failed");

`endif

@@ sv/vera_pkg.sv @@
// ----------------------------------------------------------------------------
// vera_pkg
// sizes, codes and types of the variable entry ring allocator
// ----------------------------------------------------------------------------
`default_nettype none

package vera_pkg;

  // ring geometry
  localparam int RING_BYTES    = 4096;
  localparam int HEADER_BYTES  = 16;
  localparam int GRANULE_BYTES = 8;

  localparam int OFF_W      = $clog2(RING_BYTES);
  localparam int SIZE_W     = OFF_W + 1;
  localparam int GRAN_W     = $clog2(GRANULE_BYTES);
  localparam int SLOT_COUNT = RING_BYTES / GRANULE_BYTES;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);

  // transaction field widths
  localparam int MODE_W   = 2;
  localparam int REQ_W    = 16;
  localparam int HANDLE_W = 12;
  localparam int STATUS_W = 2;
  localparam int PAY_W    = 13;
  localparam int USE_W    = 13;

  // rounded request plus header, and one more bit for compares
  localparam int ESIZE_W = REQ_W + 1;
  localparam int CMP_W   = ESIZE_W + 1;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC  = 2'd0,
    MODE_COMMIT = 2'd1,
    MODE_FRONT  = 2'd2,
    MODE_POP    = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_SPACE = 2'd1,
    STAT_NO_ENTRY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    SLOT_EMPTY     = 2'd0,
    SLOT_ALLOCATED = 2'd1,
    SLOT_COMMITTED = 2'd2,
    SLOT_PADDING   = 2'd3
  } slot_state_t;

endpackage

`default_nettype wire

@@ sv/vera_if.sv @@
// ----------------------------------------------------------------------------
// vera_if
// command and response channels of the ring allocator
// ----------------------------------------------------------------------------
`default_nettype none

interface vera_cmd_if
  import vera_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [REQ_W-1:0]    request_bytes;
  logic [HANDLE_W-1:0] entry_handle;

  modport source (output valid, mode, request_bytes, entry_handle, input ready);
  modport sink   (input valid, mode, request_bytes, entry_handle, output ready);
endinterface

interface vera_rsp_if
  import vera_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [HANDLE_W-1:0] result_handle;
  logic [PAY_W-1:0]    payload_bytes;
  logic [USE_W-1:0]    bytes_in_use;

  modport source (output valid, status, result_handle, payload_bytes, bytes_in_use,
                  input ready);
  modport sink   (input valid, status, result_handle, payload_bytes, bytes_in_use,
                  output ready);
endinterface

`default_nettype wire

@@ sv/variable_entry_ring_allocator_top.sv @@
// ----------------------------------------------------------------------------
// variable_entry_ring_allocator_top
// byte ring allocator for variable-size entries with wrap padding
// ----------------------------------------------------------------------------
//
//  channel  dir  fields                                              handshake
//  -------  ---  --------------------------------------------------  ---------
//  cmd      in   mode, request_bytes, entry_handle                   valid/ready
//  rsp      out  status, result_handle, payload_bytes, bytes_in_use  valid/ready
//
//  a transaction holds the block from acceptance through its operation
//  state and the done state back to idle; a misaligned commit goes straight
//  to done, allocate repeats its state when it pads the tail, and front
//  passes a second state when it skips padding; the steps come from the
//  slot tables: commit, front and pop read a slot, decide, then write it
//  back through one shared update path; after reset a clearing pass
//  empties all 512 slots of the slot state table; cmd.ready stays low meanwhile
//  a stalled response sits in the output register; the next command is
//  still taken and waits in the done state only if that register is full
// ----------------------------------------------------------------------------
`default_nettype none

module variable_entry_ring_allocator_top
  import vera_pkg::*;
(
  input  wire        clk,
  input  wire        rst,
  vera_cmd_if.sink   cmd,
  vera_rsp_if.source rsp
);

  // sequencer states
  typedef enum logic [7:0] {
    ST_CLEAR  = 8'b0000_0001,
    ST_IDLE   = 8'b0000_0010,
    ST_ALLOC  = 8'b0000_0100,
    ST_COMMIT = 8'b0000_1000,
    ST_FRONT  = 8'b0001_0000,
    ST_FRONT2 = 8'b0010_0000,
    ST_POP    = 8'b0100_0000,
    ST_DONE   = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  // clearing pass
  logic [SLOT_W-1:0] clr_idx, clr_idx_next;

  // ring cursors and occupancy
  logic [OFF_W-1:0]  write_offset, write_offset_next;
  logic [OFF_W-1:0]  read_offset, read_offset_next;
  logic [SIZE_W-1:0] used_bytes, used_bytes_next;

  // captured command
  logic [ESIZE_W-1:0] op_size, op_size_next;
  logic [ESIZE_W-1:0] op_esize, op_esize_next;
  logic [OFF_W-1:0]   op_handle, op_handle_next;

  // result being built
  status_t           res_status, res_status_next;
  logic [OFF_W-1:0]  res_handle, res_handle_next;
  logic [PAY_W-1:0]  res_pay, res_pay_next;

  // output register
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [HANDLE_W-1:0] out_handle;
  logic [PAY_W-1:0]    out_pay;
  logic [USE_W-1:0]    out_use;

  // slot tables: state cleared by the pass, payload size written with it on allocate
  slot_state_t       st_mem [SLOT_COUNT];
  logic [SIZE_W-1:0] pay_mem [SLOT_COUNT];
  slot_state_t       rd_state;
  logic [SIZE_W-1:0] rd_pay;

  logic              mem_we;
  logic              mem_wpay_en;
  logic [SLOT_W-1:0] mem_waddr;
  slot_state_t       mem_wstate;
  logic [SIZE_W-1:0] mem_wpay;
  logic [SLOT_W-1:0] mem_raddr;

  // request rounding at acceptance
  logic [ESIZE_W-1:0] req_ext;
  logic [ESIZE_W-1:0] req_round;

  // allocate arithmetic
  logic [SIZE_W-1:0] tail_left;
  logic [CMP_W-1:0]  need_total;
  logic [CMP_W-1:0]  esize_hdr;
  logic              room_total;
  logic              tail_fits;
  logic [SIZE_W:0]   pad_total;
  logic              pad_room;
  logic [SIZE_W-1:0] pad_pay;

  // free path shared by front and pop
  logic [SIZE_W-1:0] head_left;
  logic [SIZE_W:0]   free_span;
  logic [SIZE_W:0]   free_ro_sum;
  logic [OFF_W-1:0]  free_ro;
  logic [SIZE_W-1:0] free_used;

  logic   accept;
  logic   out_free;
  mode_t  cmd_mode;

  assign accept   = cmd.valid && cmd.ready;
  assign out_free = !out_valid || rsp.ready;
  assign cmd_mode = mode_t'(cmd.mode);

  assign cmd.ready         = (state == ST_IDLE);
  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.result_handle = out_handle;
  assign rsp.payload_bytes = out_pay;
  assign rsp.bytes_in_use  = out_use;

  // round up to a granule, then add the header
  assign req_ext   = ESIZE_W'(cmd.request_bytes);
  assign req_round = (req_ext + ESIZE_W'(GRANULE_BYTES - 1))
                     & ~ESIZE_W'(GRANULE_BYTES - 1);

  // space checks against the write cursor
  assign tail_left  = SIZE_W'(RING_BYTES) - {1'b0, write_offset};
  assign need_total = CMP_W'(op_esize) + CMP_W'(used_bytes);
  assign room_total = (need_total <= CMP_W'(RING_BYTES));
  assign esize_hdr  = CMP_W'(op_esize) + CMP_W'(HEADER_BYTES);
  assign tail_fits  = (CMP_W'(tail_left) >= esize_hdr)
                      || (CMP_W'(tail_left) == CMP_W'(op_esize));
  assign pad_total  = {1'b0, used_bytes} + {1'b0, tail_left};
  assign pad_room   = (pad_total <= (SIZE_W+1)'(RING_BYTES));
  // a tail shorter than a header becomes a header-only pad
  assign pad_pay    = (tail_left >= SIZE_W'(HEADER_BYTES))
                      ? tail_left - SIZE_W'(HEADER_BYTES) : '0;

  // padding frees up to the ring end, a real entry its header and payload
  assign head_left   = SIZE_W'(RING_BYTES) - {1'b0, read_offset};
  assign free_span   = (rd_state == SLOT_PADDING)
                       ? {1'b0, head_left}
                       : {1'b0, rd_pay} + (SIZE_W+1)'(HEADER_BYTES);
  assign free_ro_sum = (SIZE_W+1)'(read_offset) + free_span;
  assign free_ro     = free_ro_sum[OFF_W-1:0];
  // occupancy never drops below zero
  assign free_used   = ({1'b0, used_bytes} >= free_span)
                       ? SIZE_W'({1'b0, used_bytes} - free_span) : '0;

  // sequencer
  always_comb begin
    state_next        = state;
    clr_idx_next      = clr_idx;
    write_offset_next = write_offset;
    read_offset_next  = read_offset;
    used_bytes_next   = used_bytes;
    op_size_next      = op_size;
    op_esize_next     = op_esize;
    op_handle_next    = op_handle;
    res_status_next   = res_status;
    res_handle_next   = res_handle;
    res_pay_next      = res_pay;

    mem_we      = 1'b0;
    mem_wpay_en = 1'b0;
    mem_waddr   = read_offset[OFF_W-1:GRAN_W];
    mem_wstate  = SLOT_EMPTY;
    mem_wpay    = '0;
    mem_raddr   = read_offset[OFF_W-1:GRAN_W];

    unique case (state)
      ST_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_idx;
        mem_wstate   = SLOT_EMPTY;
        clr_idx_next = clr_idx + 1'b1;
        if (clr_idx == SLOT_W'(SLOT_COUNT - 1)) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          op_size_next    = req_round;
          op_esize_next   = req_round + ESIZE_W'(HEADER_BYTES);
          op_handle_next  = OFF_W'(cmd.entry_handle);
          res_status_next = STAT_OK;
          res_handle_next = '0;
          res_pay_next    = '0;
          unique case (cmd_mode)
            MODE_ALLOC: begin
              state_next = ST_ALLOC;
            end
            MODE_COMMIT: begin
              mem_raddr = cmd.entry_handle[OFF_W-1:GRAN_W];
              // an unaligned handle is ignored
              if (cmd.entry_handle[GRAN_W-1:0] == '0) begin
                state_next = ST_COMMIT;
              end else begin
                state_next = ST_DONE;
              end
            end
            MODE_FRONT: begin
              state_next = ST_FRONT;
            end
            MODE_POP: begin
              state_next = ST_POP;
            end
            default: begin
              state_next = ST_DONE;
            end
          endcase
        end
      end

      ST_ALLOC: begin
        mem_waddr = write_offset[OFF_W-1:GRAN_W];
        if (!room_total) begin
          res_status_next = STAT_NO_SPACE;
          state_next      = ST_DONE;
        end else if (tail_fits) begin
          mem_we            = 1'b1;
          mem_wpay_en       = 1'b1;
          mem_wstate        = SLOT_ALLOCATED;
          mem_wpay          = SIZE_W'(op_size);
          res_status_next   = STAT_OK;
          res_handle_next   = write_offset;
          res_pay_next      = PAY_W'(op_size);
          write_offset_next = OFF_W'(CMP_W'(write_offset) + CMP_W'(op_esize));
          used_bytes_next   = SIZE_W'(need_total);
          state_next        = ST_DONE;
        end else if (!pad_room) begin
          res_status_next = STAT_NO_SPACE;
          state_next      = ST_DONE;
        end else begin
          // pad out the tail, wrap and try again
          mem_we            = 1'b1;
          mem_wpay_en       = 1'b1;
          mem_wstate        = SLOT_PADDING;
          mem_wpay          = pad_pay;
          used_bytes_next   = SIZE_W'(pad_total);
          write_offset_next = '0;
        end
      end

      ST_COMMIT: begin
        if (rd_state == SLOT_ALLOCATED) begin
          mem_we     = 1'b1;
          mem_waddr  = op_handle[OFF_W-1:GRAN_W];
          mem_wstate = SLOT_COMMITTED;
        end
        state_next = ST_DONE;
      end

      ST_FRONT: begin
        if (rd_state == SLOT_PADDING) begin
          // skip one pad, then look again at the new read cursor
          mem_we           = 1'b1;
          mem_wstate       = SLOT_EMPTY;
          read_offset_next = free_ro;
          used_bytes_next  = free_used;
          mem_raddr        = free_ro[OFF_W-1:GRAN_W];
          state_next       = ST_FRONT2;
        end else if (rd_state == SLOT_COMMITTED) begin
          res_handle_next = read_offset;
          res_pay_next    = PAY_W'(rd_pay);
          state_next      = ST_DONE;
        end else begin
          res_status_next = STAT_NO_ENTRY;
          state_next      = ST_DONE;
        end
      end

      ST_FRONT2: begin
        if (rd_state == SLOT_COMMITTED) begin
          res_handle_next = read_offset;
          res_pay_next    = PAY_W'(rd_pay);
        end else begin
          res_status_next = STAT_NO_ENTRY;
        end
        state_next = ST_DONE;
      end

      ST_POP: begin
        if (rd_state == SLOT_PADDING || rd_state == SLOT_COMMITTED) begin
          mem_we           = 1'b1;
          mem_wstate       = SLOT_EMPTY;
          read_offset_next = free_ro;
          used_bytes_next  = free_used;
          res_handle_next  = read_offset;
          res_pay_next     = PAY_W'(rd_pay);
        end else begin
          res_status_next = STAT_NO_ENTRY;
        end
        state_next = ST_DONE;
      end

      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control and cursor registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_idx      <= '0;
      write_offset <= '0;
      read_offset  <= '0;
      used_bytes   <= '0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      clr_idx      <= clr_idx_next;
      write_offset <= write_offset_next;
      read_offset  <= read_offset_next;
      used_bytes   <= used_bytes_next;
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_size    <= op_size_next;
    op_esize   <= op_esize_next;
    op_handle  <= op_handle_next;
    res_status <= res_status_next;
    res_handle <= res_handle_next;
    res_pay    <= res_pay_next;
    if (state == ST_DONE && out_free) begin
      out_status <= STATUS_W'(res_status);
      out_handle <= HANDLE_W'(res_handle);
      out_pay    <= res_pay;
      out_use    <= USE_W'(used_bytes);
    end
  end

  // slot state table, write-first on a same-slot read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      st_mem[mem_waddr] <= mem_wstate;
    end
    if (mem_we && mem_waddr == mem_raddr) begin
      rd_state <= mem_wstate;
    end else begin
      rd_state <= st_mem[mem_raddr];
    end
  end

  // slot payload size table
  always_ff @(posedge clk) begin
    if (mem_we && mem_wpay_en) begin
      pay_mem[mem_waddr] <= mem_wpay;
    end
    if (mem_we && mem_wpay_en && mem_waddr == mem_raddr) begin
      rd_pay <= mem_wpay;
    end else begin
      rd_pay <= pay_mem[mem_raddr];
    end
  end

endmodule

`default_nettype wire

@@ sv/vera_checker.sv @@
// ----------------------------------------------------------------------------
// vera_checker
// port-level checks on the ring allocator, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module vera_checker
  import vera_pkg::*;
(
  input wire                clk,
  input wire                rst,
  input wire                cmd_valid,
  input wire                cmd_ready,
  input wire                rsp_valid,
  input wire                rsp_ready,
  input wire [STATUS_W-1:0] rsp_status,
  input wire [HANDLE_W-1:0] rsp_result_handle,
  input wire [PAY_W-1:0]    rsp_payload_bytes,
  input wire [USE_W-1:0]    rsp_bytes_in_use
);

  logic cmd_taken;
  logic rsp_failed;
  logic rsp_fields_zero;
  logic rsp_in_range;

  assign cmd_taken       = cmd_valid && cmd_ready;
  assign rsp_failed      = rsp_valid && (rsp_status != STAT_OK);
  assign rsp_fields_zero = (rsp_result_handle == '0) && (rsp_payload_bytes == '0);
  // only defined status codes, and sizes within the ring
  assign rsp_in_range    = (rsp_status == STAT_OK || rsp_status == STAT_NO_SPACE
                            || rsp_status == STAT_NO_ENTRY)
                           && rsp_bytes_in_use <= USE_W'(RING_BYTES)
                           && rsp_payload_bytes <= PAY_W'(RING_BYTES);

  // a stalled response stays offered
  `VERA_ASSERT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid)

  // clearing pass keeps commands out right after reset
  `VERA_ASSERT_NR(a_rst_busy, clk, rst |=> !cmd_ready)

  // one transaction at a time: busy straight after a command is taken
  `VERA_ASSERT(a_busy_after_cmd, clk, rst, cmd_taken |=> !cmd_ready)

  // failures carry no handle and no size
  `VERA_ASSERT(a_fail_zero, clk, rst, rsp_failed |-> rsp_fields_zero)

  // status codes, occupancy and payload sizes stay in range
  `VERA_ASSERT(a_rsp_range, clk, rst, rsp_valid |-> rsp_in_range)

endmodule

bind variable_entry_ring_allocator_top vera_checker u_vera_checker (
  .clk               (clk),
  .rst               (rst),
  .cmd_valid         (cmd.valid),
  .cmd_ready         (cmd.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_status        (rsp.status),
  .rsp_result_handle (rsp.result_handle),
  .rsp_payload_bytes (rsp.payload_bytes),
  .rsp_bytes_in_use  (rsp.bytes_in_use)
);

`default_nettype wire

@@ tb/sv/variable_entry_ring_allocator_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// variable_entry_ring_allocator_top_tb
// drives allocate, commit, front and pop transactions into the ring
// allocator, predicts every response from a behavioural copy of the ring and
// checks each response field by field under random idling and back-pressure
// ----------------------------------------------------------------------------

module variable_entry_ring_allocator_top_tb;
  import vera_pkg::*;

  // generous bound: clearing pass, ~650 transactions at worst-case gaps and
  // stalls plus the long hold-off, taken several times over
  localparam int CYCLE_LIMIT = 200000;
  // cycles waited after the last owed response at the end of each test
  localparam int SETTLE_CYCLES = 8;

  // one predicted response
  typedef struct packed {
    status_t             status;
    logic [HANDLE_W-1:0] handle;
    logic [PAY_W-1:0]    payload;
    logic [USE_W-1:0]    in_use;
  } ring_result_t;

  logic clk;
  logic rst;

  vera_cmd_if cmd_ch ();
  vera_rsp_if rsp_ch ();

  variable_entry_ring_allocator_top u_top (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  // --------------------------------------------------------------------------
  // behavioural copy of the ring
  // --------------------------------------------------------------------------
  int unsigned ring_wr;
  int unsigned ring_rd;
  int unsigned ring_used;
  slot_state_t slot_state [SLOT_COUNT];
  int unsigned slot_size  [SLOT_COUNT];

  // responses still owed by the block, oldest first
  ring_result_t expected_results [$];
  // offsets of granted allocations, candidates for commit
  logic [HANDLE_W-1:0] open_handles [$];

  // idling bounds, changed per phase by the tests
  int unsigned gap_max;
  int unsigned stall_max;
  // when non-zero the response side holds ready low for this many cycles
  int unsigned holdoff_cycles;

  // run statistics
  int unsigned errors;
  int unsigned responses_checked;
  int unsigned grants;
  int unsigned refusals;
  int unsigned pads_placed;
  int unsigned entries_released;
  int unsigned cycle_count;

  // free the entry at the read cursor and return its stored payload size;
  // a padding entry always runs to the end of the ring
  function automatic int unsigned release_front();
    int unsigned s;
    int unsigned span;
    int unsigned pay;
    s   = ring_rd / GRANULE_BYTES;
    pay = slot_size[s];
    if (slot_state[s] == SLOT_PADDING) begin
      span = RING_BYTES - ring_rd;
    end else begin
      span = pay + HEADER_BYTES;
    end
    slot_state[s] = SLOT_EMPTY;
    slot_size[s]  = 0;
    ring_rd       = (ring_rd + span) % RING_BYTES;
    // used bytes saturate at zero
    ring_used     = (ring_used >= span) ? ring_used - span : 0;
    entries_released++;
    return pay;
  endfunction

  // apply one transaction to the ring copy and return the response it causes
  function automatic ring_result_t ring_apply(mode_t op, int unsigned req,
                                              int unsigned hnd);
    ring_result_t r;
    int unsigned  sz;
    int unsigned  esz;
    int unsigned  left;
    int unsigned  s;
    bit           done;
    r = '{STAT_OK, '0, '0, '0};
    case (op)
      MODE_ALLOC: begin
        sz       = (req + GRANULE_BYTES - 1) / GRANULE_BYTES * GRANULE_BYTES;
        esz      = sz + HEADER_BYTES;
        r.status = STAT_NO_SPACE;
        done     = 1'b0;
        while (!done && esz + ring_used <= RING_BYTES) begin
          left = RING_BYTES - ring_wr;
          if (!(left >= esz + HEADER_BYTES || left == esz)) begin
            // tail too small: pad it and wrap, unless the pad itself won't fit
            if (ring_used + left > RING_BYTES) begin
              done = 1'b1;
            end else begin
              s             = ring_wr / GRANULE_BYTES;
              slot_state[s] = SLOT_PADDING;
              slot_size[s]  = (left >= HEADER_BYTES) ? left - HEADER_BYTES : 0;
              ring_used    += left;
              ring_wr       = 0;
              pads_placed++;
            end
          end else begin
            s             = ring_wr / GRANULE_BYTES;
            slot_state[s] = SLOT_ALLOCATED;
            slot_size[s]  = sz;
            r.handle      = HANDLE_W'(ring_wr);
            r.payload     = PAY_W'(sz);
            ring_wr       = (ring_wr + esz) % RING_BYTES;
            ring_used    += esz;
            r.status      = STAT_OK;
            done          = 1'b1;
          end
        end
        if (r.status == STAT_OK) grants++;
        else refusals++;
      end
      MODE_COMMIT: begin
        // only an aligned handle on an allocated slot takes effect
        if (hnd % GRANULE_BYTES == 0 && hnd < RING_BYTES) begin
          s = hnd / GRANULE_BYTES;
          if (slot_state[s] == SLOT_ALLOCATED) slot_state[s] = SLOT_COMMITTED;
        end
      end
      MODE_FRONT: begin
        // at most one leading padding entry is skipped
        if (slot_state[ring_rd / GRANULE_BYTES] == SLOT_PADDING) begin
          void'(release_front());
        end
        s = ring_rd / GRANULE_BYTES;
        if (slot_state[s] == SLOT_COMMITTED) begin
          r.handle  = HANDLE_W'(ring_rd);
          r.payload = PAY_W'(slot_size[s]);
        end else begin
          r.status = STAT_NO_ENTRY;
        end
      end
      default: begin
        s = ring_rd / GRANULE_BYTES;
        if (slot_state[s] == SLOT_PADDING || slot_state[s] == SLOT_COMMITTED) begin
          r.handle  = HANDLE_W'(ring_rd);
          r.payload = PAY_W'(release_front());
        end else begin
          r.status = STAT_NO_ENTRY;
        end
      end
    endcase
    r.in_use = USE_W'(ring_used);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // clock, reset and watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst <= 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_count, expected_results.size());
      $display("simulation failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // command side
  // --------------------------------------------------------------------------

  // offer one transaction after a random gap and hold it until accepted;
  // valid is left high so back-to-back transactions need no extra edge
  task automatic send_op(input mode_t op, input logic [REQ_W-1:0] req,
                         input logic [HANDLE_W-1:0] hnd);
    int unsigned  gap;
    ring_result_t res;
    gap = $urandom_range(0, gap_max);
    if (gap != 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid         <= 1'b1;
    cmd_ch.mode          <= op;
    cmd_ch.request_bytes <= req;
    cmd_ch.entry_handle  <= hnd;
    do @(posedge clk); while (!cmd_ch.ready);
    // accepted at this edge: predict straight away
    res = ring_apply(op, req, hnd);
    expected_results.push_back(res);
    if (op == MODE_ALLOC && res.status == STAT_OK) open_handles.push_back(res.handle);
  endtask

  // one random transaction, biased towards full allocate/commit/pop lifecycles
  task automatic send_random_op();
    mode_t                op;
    logic [REQ_W-1:0]     req;
    logic [HANDLE_W-1:0]  hnd;
    int unsigned          pick;
    int unsigned          idx;
    pick = $urandom_range(0, 99);
    hnd  = HANDLE_W'($urandom);
    // mostly small entries so the ring wraps often, rarely anything at all
    case ($urandom_range(0, 9))
      0:       req = REQ_W'($urandom);
      1, 2:    req = REQ_W'($urandom_range(0, RING_BYTES));
      default: req = REQ_W'($urandom_range(0, 320));
    endcase
    if (pick < 35) begin
      op = MODE_ALLOC;
    end else if (pick < 60) begin
      op = MODE_COMMIT;
      // usually a live allocation, otherwise a stray handle
      if (open_handles.size() != 0 && $urandom_range(0, 4) != 0) begin
        idx = $urandom_range(0, open_handles.size() - 1);
        hnd = open_handles[idx];
        open_handles.delete(idx);
      end
    end else if (pick < 75) begin
      op = MODE_FRONT;
    end else begin
      op = MODE_POP;
    end
    send_op(op, req, hnd);
  endtask

  // stop offering and let every owed response come back
  task automatic wait_idle();
    cmd_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // response side: random stalls, optional long hold-off, checking
  // --------------------------------------------------------------------------
  initial begin : response_check
    int unsigned  pause;
    ring_result_t want;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (holdoff_cycles != 0) begin
        // long hold-off so the block fills and stalls its command side
        rsp_ch.ready <= 1'b0;
        repeat (holdoff_cycles) @(posedge clk);
        holdoff_cycles = 0;
      end
      pause = $urandom_range(0, stall_max);
      if (pause != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      // transaction completed at this edge
      responses_checked++;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t unexpected response: status=%0d handle=%0d payload=%0d in_use=%0d",
                 $time, rsp_ch.status, rsp_ch.result_handle, rsp_ch.payload_bytes,
                 rsp_ch.bytes_in_use);
      end else begin
        want = expected_results.pop_front();
        if (rsp_ch.status !== want.status || rsp_ch.result_handle !== want.handle ||
            rsp_ch.payload_bytes !== want.payload || rsp_ch.bytes_in_use !== want.in_use)
        begin
          errors++;
          $display("%0t mismatch: expected status=%0d handle=%0d payload=%0d in_use=%0d",
                   $time, want.status, want.handle, want.payload, want.in_use);
          $display("%0t           actual   status=%0d handle=%0d payload=%0d in_use=%0d",
                   $time, rsp_ch.status, rsp_ch.result_handle, rsp_ch.payload_bytes,
                   rsp_ch.bytes_in_use);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // empty ring: front and pop refuse, an oversized request is refused,
  // the smallest entry fits and is not visible until committed
  task automatic test_empty_ring();
    send_op(MODE_FRONT, '0, '0);
    send_op(MODE_POP,   '0, '0);
    send_op(MODE_ALLOC, '1, '1);
    send_op(MODE_ALLOC, '0, '0);
    send_op(MODE_FRONT, '0, '0);
    wait_idle();
  endtask

  // commit ignores misaligned handles and only marks allocated slots,
  // payload sizes round up to the granule
  task automatic test_commit_rules();
    send_op(MODE_COMMIT, '0, HANDLE_W'(3));
    send_op(MODE_COMMIT, '0, '1);
    send_op(MODE_COMMIT, '0, '0);
    send_op(MODE_FRONT,  '0, '0);
    send_op(MODE_POP,    '0, '0);
    send_op(MODE_ALLOC,  REQ_W'(1), '0);
    send_op(MODE_COMMIT, '0, HANDLE_W'(16));
    send_op(MODE_POP,    '0, '0);
    wait_idle();
  endtask

  // an entry that fills the tail exactly wraps the cursor without padding
  task automatic test_exact_fit_wrap();
    send_op(MODE_ALLOC,  REQ_W'(4040), '0);
    send_op(MODE_COMMIT, '0, HANDLE_W'(40));
    send_op(MODE_POP,    '0, '0);
    wait_idle();
  endtask

  // tail padding that fills the ring so the allocation still fails,
  // front skipping the pad, and pop freeing a pad directly
  task automatic test_tail_padding();
    send_op(MODE_ALLOC,  REQ_W'(4056), '0);
    send_op(MODE_ALLOC,  '0, '0);
    send_op(MODE_COMMIT, '0, '0);
    send_op(MODE_FRONT,  '0, '0);
    send_op(MODE_POP,    '0, '0);
    send_op(MODE_FRONT,  '0, '0);
    send_op(MODE_ALLOC,  REQ_W'(4056), '0);
    send_op(MODE_ALLOC,  '0, '0);
    send_op(MODE_COMMIT, '0, '0);
    send_op(MODE_POP,    '0, '0);
    send_op(MODE_POP,    '0, '0);
    wait_idle();
  endtask

  // response side holds off while commands keep coming back to back
  task automatic test_backpressure();
    gap_max        = 0;
    stall_max      = 0;
    holdoff_cycles = 300;
    repeat (24) send_random_op();
    wait_idle();
  endtask

  // long random run in phases of differing idling, starting with none
  task automatic test_random_traffic(input int unsigned count);
    int unsigned bounds [3];
    bounds = '{0, 4, 18};
    open_handles.delete();
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        gap_max   = (i == 0) ? 0 : bounds[$urandom_range(0, 2)];
        stall_max = (i == 0) ? 0 : bounds[$urandom_range(0, 2)];
      end
      send_random_op();
    end
    wait_idle();
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    cmd_ch.valid         <= 1'b0;
    cmd_ch.mode          <= MODE_ALLOC;
    cmd_ch.request_bytes <= '0;
    cmd_ch.entry_handle  <= '0;
    ring_wr           = 0;
    ring_rd           = 0;
    ring_used         = 0;
    foreach (slot_state[i]) begin
      slot_state[i] = SLOT_EMPTY;
      slot_size[i]  = 0;
    end
    gap_max           = 18;
    stall_max         = 18;
    holdoff_cycles    = 0;
    errors            = 0;
    responses_checked = 0;
    grants            = 0;
    refusals          = 0;
    pads_placed       = 0;
    entries_released  = 0;
    cycle_count       = 0;

    // the block clears its slot table after reset; send_op waits on ready
    @(posedge clk);
    while (rst) @(posedge clk);

    test_empty_ring();
    test_commit_rules();
    test_exact_fit_wrap();
    test_tail_padding();
    test_backpressure();
    gap_max   = 18;
    stall_max = 18;
    test_random_traffic(600);

    $display("checked %0d responses: %0d allocations granted, %0d refused",
             responses_checked, grants, refusals);
    $display("%0d tail pads placed, %0d entries released, %0d errors",
             pads_placed, entries_released, errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/vera_pkg.sv
sv/vera_if.sv
sv/variable_entry_ring_allocator_top.sv
sv/vera_checker.sv
tb/sv/variable_entry_ring_allocator_top_tb.sv
